/* rtl/pdc_pkg.sv */
`default_nettype none
package pdc_pkg;

	// default sizing of the descriptor ring and the chunk
	localparam int QUEUE_DEPTH_DEF = 128;
	localparam int CHUNK_BYTES_DEF = 8;

	// field widths
	localparam int ADDR_W  = 16;
	localparam int LEN_W   = 8;
	localparam int CLEN_W  = 4;

	// command codes of an input word
	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_POLL    = 1'b1;

	// status codes of a result word
	localparam logic STATUS_CHUNK   = 1'b0;
	localparam logic STATUS_DROPPED = 1'b1;

	// classified operation handed from the front to the back
	typedef struct packed {
		logic              is_poll;
		logic [ADDR_W-1:0] buf_addr;
		logic [LEN_W-1:0]  pkt_len;
	} pdc_op_t;

	// queue handshake between front and back
	typedef struct packed {
		logic    valid;
		pdc_op_t op;
	} pdc_opq_t;

endpackage
`default_nettype wire

/* rtl/pdc_if.sv */
`default_nettype none
// request channel: one word per enqueue or poll
interface pdc_req_if import pdc_pkg::*;;
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [ADDR_W-1:0] buf_addr;
	logic [LEN_W-1:0]  pkt_len;

	modport source (output valid, cmd, buf_addr, pkt_len, input ready);
	modport sink   (input valid, cmd, buf_addr, pkt_len, output ready);
endinterface

// response channel: one word per chunk or dropped enqueue
interface pdc_rsp_if import pdc_pkg::*;;
	logic              valid;
	logic              ready;
	logic              status;
	logic [ADDR_W-1:0] chunk_addr;
	logic [CLEN_W-1:0] chunk_len;
	logic              last_chunk;

	modport source (output valid, status, chunk_addr, chunk_len, last_chunk, input ready);
	modport sink   (input valid, status, chunk_addr, chunk_len, last_chunk, output ready);
endinterface
`default_nettype wire

/* rtl/pdc_ram.sv */
`default_nettype none
module pdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/pdc_front.sv */
`default_nettype none
module pdc_front import pdc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	pdc_req_if.sink   req,
	output pdc_opq_t  opq,
	input  wire logic opq_ready
);

	localparam int FIFO_DEPTH = 2;

	pdc_op_t              slot_q [FIFO_DEPTH];
	logic                 wr_idx_q;
	logic                 rd_idx_q;
	logic [1:0]           count_q;
	logic                 push;
	logic                 pop;
	pdc_op_t              op_in;

	// classify the incoming word
	always_comb begin
		op_in.is_poll  = (req.cmd == CMD_POLL);
		op_in.buf_addr = req.buf_addr;
		op_in.pkt_len  = req.pkt_len;
	end

	assign req.ready = (count_q != 2'(FIFO_DEPTH));
	assign push      = req.valid && req.ready;
	assign opq.valid = (count_q != 2'd0);
	assign opq.op    = slot_q[rd_idx_q];
	assign pop       = opq.valid && opq_ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_idx_q] <= op_in;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= 1'b0;
			rd_idx_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_idx_q <= ~wr_idx_q;
			end
			if (pop) begin
				rd_idx_q <= ~rd_idx_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/pdc_back.sv */
`default_nettype none
module pdc_back import pdc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  pdc_opq_t  opq,
	output logic      opq_ready,
	pdc_rsp_if.source rsp
);

	localparam int              PTR_W   = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [LEN_W-1:0] CHUNK_W = LEN_W'(CHUNK_BYTES);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic              state_q;
	logic [PTR_W-1:0]  wptr_q;
	logic [PTR_W-1:0]  rptr_q;
	logic              sending_q;
	logic [LEN_W-1:0]  offset_q;
	logic              out_valid_q;
	logic              status_q;
	logic [ADDR_W-1:0] chunk_addr_q;
	logic [CLEN_W-1:0] chunk_len_q;
	logic              last_q;

	logic [PTR_W-1:0]  wptr_next;
	logic [PTR_W-1:0]  rptr_next;
	logic              ring_full;
	logic              ring_empty;
	logic              pop;
	logic              do_write;
	logic              do_read;
	logic [ADDR_W-1:0] head_addr;
	logic [LEN_W-1:0]  head_len;
	logic [LEN_W-1:0]  remaining;
	logic              more;

	// ring pointer arithmetic
	assign wptr_next  = (wptr_q == PTR_MAX) ? '0 : wptr_q + PTR_W'(1);
	assign rptr_next  = (rptr_q == PTR_MAX) ? '0 : rptr_q + PTR_W'(1);
	assign ring_full  = (wptr_next == rptr_q);
	assign ring_empty = (rptr_q == wptr_q);

	// take an op only when idle and the result register is free
	assign opq_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign pop       = opq.valid && opq_ready;
	assign do_write  = pop && !opq.op.is_poll && !ring_full;
	assign do_read   = pop && opq.op.is_poll && (sending_q || !ring_empty);

	// descriptor stores
	pdc_ram #(.WIDTH(ADDR_W), .DEPTH(QUEUE_DEPTH)) u_addr_ram (
		.clk   (clk),
		.we    (do_write),
		.waddr (wptr_q),
		.wdata (opq.op.buf_addr),
		.re    (do_read),
		.raddr (rptr_q),
		.rdata (head_addr)
	);

	pdc_ram #(.WIDTH(LEN_W), .DEPTH(QUEUE_DEPTH)) u_len_ram (
		.clk   (clk),
		.we    (do_write),
		.waddr (wptr_q),
		.wdata (opq.op.pkt_len),
		.re    (do_read),
		.raddr (rptr_q),
		.rdata (head_len)
	);

	// bytes left in the head packet
	assign remaining = (head_len >= offset_q) ? head_len - offset_q : '0;
	assign more      = (remaining > CHUNK_W);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wptr_q      <= '0;
			rptr_q      <= '0;
			sending_q   <= 1'b0;
			offset_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (do_write) begin
						wptr_q <= wptr_next;
					end
					if (pop && !opq.op.is_poll && ring_full) begin
						out_valid_q <= 1'b1;
					end
					if (do_read) begin
						state_q <= ST_READ;
						if (!sending_q) begin
							sending_q <= 1'b1;
							offset_q  <= '0;
						end
					end
				end
				ST_READ: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
					if (more) begin
						offset_q <= offset_q + CHUNK_W;
					end else begin
						sending_q <= 1'b0;
						offset_q  <= '0;
						rptr_q    <= rptr_next;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			status_q     <= STATUS_CHUNK;
			chunk_addr_q <= head_addr + ADDR_W'(offset_q);
			chunk_len_q  <= more ? CHUNK_W[CLEN_W-1:0] : remaining[CLEN_W-1:0];
			last_q       <= !more;
		end else if (pop && !opq.op.is_poll && ring_full) begin
			status_q     <= STATUS_DROPPED;
			chunk_addr_q <= '0;
			chunk_len_q  <= '0;
			last_q       <= 1'b0;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.chunk_addr = chunk_addr_q;
	assign rsp.chunk_len  = chunk_len_q;
	assign rsp.last_chunk = last_q;

endmodule
`default_nettype wire

/* rtl/packet_descriptor_chunker_unit.sv */
// Packet descriptor chunker.
// The req channel takes one word per operation: cmd enqueue stores a
// descriptor (buf_addr, pkt_len) in a ring of QUEUE_DEPTH - 1 usable slots,
// cmd poll asks for the next chunk of the head packet. The rsp channel gives
// at most one word per request: a chunk (address, up to CHUNK_BYTES bytes,
// last flag) for a poll with work pending, or status dropped with zeroed
// fields for an enqueue into a full ring. Successful enqueues and polls on
// an empty ring give no word.
// A two-entry queue sits behind req, so requests keep being taken while a
// result waits on rsp. Enqueues retire one per cycle while no poll is in
// flight and no result waits. A poll result passes through the queue, the
// registered read of the descriptor RAM and the single result register; no
// new op is taken until the last result has left that register. A low
// rsp.ready holds the result and, once the queue has filled, drops req.ready.
// Reset empties the ring and the queue; descriptor RAM contents are not
// cleared and need no clearing pass.
`default_nettype none
module packet_descriptor_chunker_unit import pdc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pdc_req_if.sink   req,
	pdc_rsp_if.source rsp
);

	pdc_opq_t opq;
	logic     opq_ready;

	// accept and classify
	pdc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.opq       (opq),
		.opq_ready (opq_ready)
	);

	// ring and chunking
	pdc_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CHUNK_BYTES (CHUNK_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.opq       (opq),
		.opq_ready (opq_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import pdc_pkg::*;

	localparam int ITEM_TARGET = 750;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_WAIT  = 30;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH_DEF);

	// how the expectation of a stimulus word is obtained
	typedef enum logic [1:0] {ROW_CHECKED, ROW_SILENT, ROW_LITERAL} row_kind_t;

	// receiver behaviour on the result channel
	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_BLOCKED} rx_mode_t;

	// shape of one random phase
	typedef enum logic [1:0] {PH_MIXED, PH_FILL, PH_DRAIN} phase_t;

	typedef struct packed {
		logic              status;
		logic [ADDR_W-1:0] chunk_addr;
		logic [CLEN_W-1:0] chunk_len;
		logic              last_chunk;
	} chunk_word_t;

	typedef struct {
		logic              cmd;
		logic [ADDR_W-1:0] buf_addr;
		logic [LEN_W-1:0]  pkt_len;
		row_kind_t         kind;
		chunk_word_t       word;
	} req_word_t;

	logic clk = 1'b0;
	logic arst_n;

	pdc_req_if req_if();
	pdc_rsp_if rsp_if();

	packet_descriptor_chunker_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the descriptor ring
	logic [ADDR_W-1:0] ring_addr [QUEUE_DEPTH_DEF];
	logic [LEN_W-1:0]  ring_len  [QUEUE_DEPTH_DEF];
	logic [PTR_W-1:0]  ring_wr;
	logic [PTR_W-1:0]  ring_rd;
	logic              pkt_active;
	logic [LEN_W-1:0]  pkt_sent;

	chunk_word_t chunk_q [$];
	req_word_t   dir_rows [$];
	req_word_t   cur_word;

	int n_errors     = 0;
	int n_counted    = 0;
	int n_enqueued   = 0;
	int n_dropped    = 0;
	int n_empty_poll = 0;
	int n_chunks     = 0;
	int n_last       = 0;
	int idle_cycles  = 0;
	int burst_left   = 0;

	// next chunk of the head packet, or a drop report for a full ring
	function automatic bit predict_chunk(input logic cmd, input logic [ADDR_W-1:0] addr,
			input logic [LEN_W-1:0] len, output chunk_word_t w);
		logic [PTR_W-1:0] nxt;
		logic [LEN_W-1:0] left;
		w = '0;
		if (cmd == CMD_ENQUEUE) begin
			nxt = (ring_wr == PTR_W'(QUEUE_DEPTH_DEF - 1)) ? '0 : ring_wr + PTR_W'(1);
			if (nxt == ring_rd) begin
				w.status = STATUS_DROPPED;
				return 1'b1;
			end
			ring_addr[ring_wr] = addr;
			ring_len[ring_wr]  = len;
			ring_wr = nxt;
			return 1'b0;
		end
		if (!pkt_active) begin
			if (ring_rd == ring_wr)
				return 1'b0;
			pkt_active = 1'b1;
			pkt_sent   = '0;
		end
		left = ring_len[ring_rd] - pkt_sent;
		w.status     = STATUS_CHUNK;
		w.chunk_addr = ring_addr[ring_rd] + ADDR_W'(pkt_sent);
		if (left > CHUNK_BYTES_DEF) begin
			w.chunk_len = CLEN_W'(CHUNK_BYTES_DEF);
			pkt_sent    = pkt_sent + LEN_W'(CHUNK_BYTES_DEF);
		end else begin
			w.chunk_len  = left[CLEN_W-1:0];
			w.last_chunk = 1'b1;
			pkt_active   = 1'b0;
			pkt_sent     = '0;
			ring_rd = (ring_rd == PTR_W'(QUEUE_DEPTH_DEF - 1)) ? '0 : ring_rd + PTR_W'(1);
		end
		return 1'b1;
	endfunction

	// packet lengths lean small so packets finish within a few polls
	function automatic logic [LEN_W-1:0] rand_pkt_len();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			return LEN_W'($urandom_range(0, 20));
		if (pick < 9)
			return LEN_W'($urandom);
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return LEN_W'(CHUNK_BYTES_DEF);
			2: return LEN_W'(CHUNK_BYTES_DEF + 1);
			default: return 8'hFF;
		endcase
	endfunction

	// buffers near the top of the address space exercise the wrap
	function automatic logic [ADDR_W-1:0] rand_buf_addr();
		if ($urandom_range(0, 4) == 0)
			return 16'hFFF0 | ADDR_W'($urandom_range(0, 15));
		return ADDR_W'($urandom);
	endfunction

	task automatic add_row(input logic cmd, input logic [ADDR_W-1:0] addr,
			input logic [LEN_W-1:0] len, input row_kind_t kind, input chunk_word_t w);
		req_word_t r;
		r.cmd      = cmd;
		r.buf_addr = addr;
		r.pkt_len  = len;
		r.kind     = kind;
		r.word     = w;
		dir_rows.push_back(r);
	endtask

	// entered and left at a falling edge; bursts of words with gaps between
	task automatic send_word(input req_word_t w);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 20);
		end
		burst_left--;
		cur_word = w;
		req_if.valid    <= 1'b1;
		req_if.cmd      <= w.cmd;
		req_if.buf_addr <= w.buf_addr;
		req_if.pkt_len  <= w.pkt_len;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random(input logic cmd, input logic [LEN_W-1:0] len);
		req_word_t w;
		w.cmd      = cmd;
		w.buf_addr = rand_buf_addr();
		w.pkt_len  = len;
		w.kind     = ROW_CHECKED;
		w.word     = '0;
		send_word(w);
	endtask

	// receiver stall pattern, changing mode every so often
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 120);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN:   rsp_if.ready <= 1'b1;
			RX_RANDOM: rsp_if.ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: rsp_if.ready <= (rx_left % 4 == 0);
			default:   rsp_if.ready <= (rx_left < 4);
		endcase
	end

	// word acceptance on both channels, prediction, checking, watchdog
	always @(posedge clk) begin
		chunk_word_t pw;
		chunk_word_t e;
		bit          has;
		if (arst_n) begin
			idle_cycles++;
			if (req_if.valid && req_if.ready) begin
				idle_cycles = 0;
				has = predict_chunk(cur_word.cmd, cur_word.buf_addr, cur_word.pkt_len, pw);
				case (cur_word.kind)
					ROW_CHECKED: if (has) chunk_q.push_back(pw);
					ROW_LITERAL: chunk_q.push_back(cur_word.word);
					default: ;
				endcase
				if (cur_word.cmd == CMD_ENQUEUE) begin
					n_enqueued++;
					if (has)
						n_dropped++;
				end else if (!has) begin
					n_empty_poll++;
				end
				if (cur_word.cmd == CMD_ENQUEUE || has)
					n_counted++;
			end
			if (rsp_if.valid && rsp_if.ready) begin
				idle_cycles = 0;
				if (chunk_q.size() == 0) begin
					$display("%0t: result word with nothing expected: status %0d addr %h len %0d last %0d",
						$time, rsp_if.status, rsp_if.chunk_addr, rsp_if.chunk_len,
						rsp_if.last_chunk);
					n_errors++;
				end else begin
					e = chunk_q.pop_front();
					if (rsp_if.status !== e.status) begin
						$display("%0t: status expected %0d actual %0d", $time, e.status,
							rsp_if.status);
						n_errors++;
					end
					if (rsp_if.chunk_addr !== e.chunk_addr) begin
						$display("%0t: chunk_addr expected %h actual %h", $time, e.chunk_addr,
							rsp_if.chunk_addr);
						n_errors++;
					end
					if (rsp_if.chunk_len !== e.chunk_len) begin
						$display("%0t: chunk_len expected %0d actual %0d", $time, e.chunk_len,
							rsp_if.chunk_len);
						n_errors++;
					end
					if (rsp_if.last_chunk !== e.last_chunk) begin
						$display("%0t: last_chunk expected %0d actual %0d", $time, e.last_chunk,
							rsp_if.last_chunk);
						n_errors++;
					end
					if (e.status == STATUS_CHUNK) begin
						n_chunks++;
						if (e.last_chunk)
							n_last++;
					end
				end
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles, %0d results outstanding",
					$time, idle_cycles, chunk_q.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		phase_t ph;
		int     first_phase;
		int     n;
		int     used;
		int     poll_pct;

		arst_n          = 1'b0;
		req_if.valid    = 1'b0;
		req_if.cmd      = CMD_ENQUEUE;
		req_if.buf_addr = '0;
		req_if.pkt_len  = '0;
		rsp_if.ready    = 1'b0;
		ring_wr    = '0;
		ring_rd    = '0;
		pkt_active = 1'b0;
		pkt_sent   = '0;
		first_phase = 1;

		// directed words: empty ring, zero length, exact and odd chunking, address wrap
		add_row(CMD_POLL,    16'h0000, 8'd0,   ROW_SILENT,  '0);
		add_row(CMD_ENQUEUE, 16'h1234, 8'd0,   ROW_SILENT,  '0);
		add_row(CMD_POLL,    16'h0000, 8'd0,   ROW_LITERAL, {STATUS_CHUNK, 16'h1234, 4'd0, 1'b1});
		add_row(CMD_POLL,    16'hFFFF, 8'hFF,  ROW_SILENT,  '0);
		add_row(CMD_ENQUEUE, 16'hFFFC, 8'd17,  ROW_SILENT,  '0);
		add_row(CMD_ENQUEUE, 16'h0000, 8'd8,   ROW_SILENT,  '0);
		add_row(CMD_ENQUEUE, 16'h00FF, 8'd1,   ROW_SILENT,  '0);
		add_row(CMD_POLL,    16'h0000, 8'd0,   ROW_LITERAL, {STATUS_CHUNK, 16'hFFFC, 4'd8, 1'b0});
		add_row(CMD_POLL,    16'h0000, 8'd0,   ROW_CHECKED, '0);
		add_row(CMD_ENQUEUE, 16'hFFFF, 8'hFF,  ROW_SILENT,  '0);
		add_row(CMD_POLL,    16'h0000, 8'd0,   ROW_CHECKED, '0);
		add_row(CMD_POLL,    16'h0000, 8'd0,   ROW_LITERAL, {STATUS_CHUNK, 16'h0000, 4'd8, 1'b1});
		add_row(CMD_POLL,    16'h0000, 8'd0,   ROW_LITERAL, {STATUS_CHUNK, 16'h00FF, 4'd1, 1'b1});
		add_row(CMD_POLL,    16'h0000, 8'd0,   ROW_LITERAL, {STATUS_CHUNK, 16'hFFFF, 4'd8, 1'b0});
		add_row(CMD_POLL,    16'hAAAA, 8'h55,  ROW_CHECKED, '0);
		add_row(CMD_ENQUEUE, 16'hAAAA, 8'h55,  ROW_SILENT,  '0);
		add_row(CMD_ENQUEUE, 16'h5555, 8'hAA,  ROW_SILENT,  '0);
		add_row(CMD_POLL,    16'h5555, 8'hAA,  ROW_CHECKED, '0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i]);

		// random phases; the first one always fills the ring to overflow
		while (n_counted < ITEM_TARGET) begin
			if (first_phase == 1)
				ph = PH_FILL;
			else
				case ($urandom_range(0, 9))
					6, 7:    ph = PH_FILL;
					8, 9:    ph = PH_DRAIN;
					default: ph = PH_MIXED;
				endcase
			first_phase = 0;
			case (ph)
				PH_FILL: begin
					used = int'(ring_wr) - int'(ring_rd);
					if (used < 0)
						used += QUEUE_DEPTH_DEF;
					while (used < QUEUE_DEPTH_DEF - 1) begin
						send_random(CMD_ENQUEUE, ($urandom_range(0, 3) == 0) ?
							rand_pkt_len() : LEN_W'($urandom_range(0, 12)));
						used++;
					end
					n = $urandom_range(1, 3);
					repeat (n)
						send_random(CMD_ENQUEUE, LEN_W'($urandom));
				end
				PH_DRAIN: begin
					while (pkt_active || ring_rd != ring_wr)
						send_random(CMD_POLL, LEN_W'($urandom));
					n = $urandom_range(1, 2);
					repeat (n)
						send_random(CMD_POLL, LEN_W'($urandom));
				end
				default: begin
					n        = $urandom_range(10, 40);
					poll_pct = $urandom_range(30, 70);
					repeat (n) begin
						if ($urandom_range(1, 100) <= poll_pct)
							send_random(CMD_POLL, LEN_W'($urandom));
						else
							send_random(CMD_ENQUEUE, rand_pkt_len());
					end
				end
			endcase
		end

		// let every outstanding result arrive, then a short quiet spell
		req_if.valid <= 1'b0;
		while (chunk_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		$display("covered %0d enqueues with %0d dropped on a full ring, %0d polls on an empty ring",
			n_enqueued, n_dropped, n_empty_poll);
		$display("checked %0d chunk words, %0d of them closing a packet", n_chunks, n_last);
		if (n_errors == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("FAIL");
		end
		$finish;
	end

endmodule
